FILE: design/sed_pkg.sv
`default_nettype none
package sed_pkg;

  // bytes sent ahead of a failed escape
  typedef enum logic [2:0] {
    PRE_NONE,
    PRE_BS_X,
    PRE_BS_X_H,
    PRE_BS_U,
    PRE_BS_U_BRACE
  } pre_kind_e;

  // bytes that close the handling of one item
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_CHAR,
    TAIL_BS_BYTE,
    TAIL_HEX,
    TAIL_UTF8
  } tail_kind_e;

  typedef enum logic [1:0] {
    EMIT_DIRECT,
    EMIT_PRE,
    EMIT_REP,
    EMIT_TAIL
  } emit_sel_e;

  typedef struct packed {
    logic       load;
    logic       load_first;
    logic       clear_code;
    logic       push_digit;
    pre_kind_e  pre_kind;
    tail_kind_e tail_kind;
    logic       emit;
    emit_sel_e  sel;
    logic [1:0] idx;
    logic       run_last;
    logic       string_end;
  } sed_cmd_t;

  typedef struct packed {
    logic       is_bs;
    logic       is_quote;
    logic       is_esc_char;
    logic       is_x;
    logic       is_u;
    logic       is_lbrace;
    logic       is_rbrace;
    logic       hex_ok;
    logic       grow_ok;
    logic       cnt_nz;
    logic       cp_ok;
    logic [2:0] cp_len;
    logic       rep_at_end;
    logic       out_can_load;
  } sed_stat_t;

endpackage
`default_nettype wire

FILE: design/sed_dp.sv
`default_nettype none
module sed_dp #(
  parameter int MAX_HEX_DIGITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        in_byte_i,
  input  wire sed_pkg::sed_cmd_t cmd_i,
  output sed_pkg::sed_stat_t     stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_run_last_o,
  output logic                   out_string_end_o
);

  localparam int CntW = $clog2(MAX_HEX_DIGITS + 1);
  localparam int IdxW = (MAX_HEX_DIGITS > 1) ? $clog2(MAX_HEX_DIGITS) : 1;
  localparam logic [20:0] GrowLimit = 21'(32'h10ffff / 32'd16);

  localparam logic [7:0] ChBs     = 8'h5c;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 5'(c[3:0]) + 5'd9;
    end
    return v;
  endfunction

  logic [7:0]      first_q;
  logic [20:0]     code_q;
  logic [7:0]      store_q [MAX_HEX_DIGITS];
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] rep_ptr_q;
  logic            pre_u_q;
  logic            pre_h_q;
  logic [7:0]      tail_q [4];
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_run_last_q;
  logic            out_string_end_q;

  logic [4:0] hv;
  logic [4:0] first_hv;
  logic [7:0] tail_w [4];
  logic [7:0] pre_byte;
  logic [7:0] esc_char;
  logic [7:0] emit_byte;
  logic       can_load;

  assign hv       = hex_val(in_byte_i);
  assign first_hv = hex_val(first_q);
  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.is_bs        = (in_byte_i == ChBs);
    stat_o.is_quote     = (in_byte_i == ChQuote);
    stat_o.is_esc_char  = (in_byte_i == ChN) || (in_byte_i == ChT) || (in_byte_i == ChR);
    stat_o.is_x         = (in_byte_i == ChX);
    stat_o.is_u         = (in_byte_i == ChU);
    stat_o.is_lbrace    = (in_byte_i == ChLbrace);
    stat_o.is_rbrace    = (in_byte_i == ChRbrace);
    stat_o.hex_ok       = !hv[4];
    stat_o.grow_ok      = (cnt_q < CntW'(MAX_HEX_DIGITS)) && (code_q <= GrowLimit);
    stat_o.cnt_nz       = (cnt_q != '0);
    stat_o.cp_ok        = !(code_q >= 21'h00d800 && code_q <= 21'h00dfff) &&
                          (code_q <= 21'h10ffff);
    if (code_q <= 21'h00007f) begin
      stat_o.cp_len = 3'd1;
    end else if (code_q <= 21'h0007ff) begin
      stat_o.cp_len = 3'd2;
    end else if (code_q <= 21'h00ffff) begin
      stat_o.cp_len = 3'd3;
    end else begin
      stat_o.cp_len = 3'd4;
    end
    stat_o.rep_at_end   = ((CntW'(rep_ptr_q) + CntW'(1)) == cnt_q);
    stat_o.out_can_load = can_load;
  end

  always_comb begin
    if (in_byte_i == ChN) begin
      esc_char = 8'h0a;
    end else if (in_byte_i == ChT) begin
      esc_char = 8'h09;
    end else begin
      esc_char = 8'h0d;
    end
  end

  always_comb begin
    tail_w[0] = in_byte_i;
    tail_w[1] = in_byte_i;
    tail_w[2] = 8'h00;
    tail_w[3] = 8'h00;
    unique case (cmd_i.tail_kind)
      sed_pkg::TAIL_CHAR: begin
        tail_w[0] = esc_char;
      end
      sed_pkg::TAIL_BS_BYTE: begin
        tail_w[0] = ChBs;
        tail_w[1] = in_byte_i;
      end
      sed_pkg::TAIL_HEX: begin
        tail_w[0] = {first_hv[3:0], hv[3:0]};
      end
      sed_pkg::TAIL_UTF8: begin
        if (code_q <= 21'h00007f) begin
          tail_w[0] = {1'b0, code_q[6:0]};
        end else if (code_q <= 21'h0007ff) begin
          tail_w[0] = {3'b110, code_q[10:6]};
          tail_w[1] = {2'b10, code_q[5:0]};
        end else if (code_q <= 21'h00ffff) begin
          tail_w[0] = {4'b1110, code_q[15:12]};
          tail_w[1] = {2'b10, code_q[11:6]};
          tail_w[2] = {2'b10, code_q[5:0]};
        end else begin
          tail_w[0] = {5'b11110, code_q[20:18]};
          tail_w[1] = {2'b10, code_q[17:12]};
          tail_w[2] = {2'b10, code_q[11:6]};
          tail_w[3] = {2'b10, code_q[5:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.idx)
      2'd0:    pre_byte = ChBs;
      2'd1:    pre_byte = pre_u_q ? ChU : ChX;
      default: pre_byte = pre_h_q ? first_q : ChLbrace;
    endcase
  end

  always_comb begin
    unique case (cmd_i.sel)
      sed_pkg::EMIT_DIRECT: emit_byte = tail_w[0];
      sed_pkg::EMIT_PRE:    emit_byte = pre_byte;
      sed_pkg::EMIT_REP:    emit_byte = store_q[rep_ptr_q];
      sed_pkg::EMIT_TAIL:   emit_byte = tail_q[cmd_i.idx];
    endcase
  end

  // control side of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      code_q      <= '0;
      cnt_q       <= '0;
      rep_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_first) begin
        first_q <= in_byte_i;
      end
      if (cmd_i.clear_code) begin
        code_q <= '0;
        cnt_q  <= '0;
      end else if (cmd_i.push_digit) begin
        code_q <= {code_q[16:0], hv[3:0]};
        cnt_q  <= cnt_q + CntW'(1);
      end
      if (cmd_i.load) begin
        rep_ptr_q <= '0;
      end else if (cmd_i.emit && cmd_i.sel == sed_pkg::EMIT_REP) begin
        rep_ptr_q <= rep_ptr_q + IdxW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_digit) begin
      store_q[cnt_q[IdxW-1:0]] <= in_byte_i;
    end
    if (cmd_i.load) begin
      pre_u_q <= (cmd_i.pre_kind == sed_pkg::PRE_BS_U) ||
                 (cmd_i.pre_kind == sed_pkg::PRE_BS_U_BRACE);
      pre_h_q <= (cmd_i.pre_kind == sed_pkg::PRE_BS_X_H);
      tail_q  <= tail_w;
    end
    if (cmd_i.emit) begin
      out_byte_q       <= emit_byte;
      out_run_last_q   <= cmd_i.run_last;
      out_string_end_q <= cmd_i.string_end;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_run_last_o   = out_run_last_q;
  assign out_string_end_o = out_string_end_q;

endmodule
`default_nettype wire

FILE: design/sed_ctrl.sv
`default_nettype none
module sed_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  input  wire sed_pkg::sed_stat_t stat_i,
  output sed_pkg::sed_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_X_FIRST,
    MODE_X_SECOND,
    MODE_U_OPEN,
    MODE_U_DIGITS
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_REP,
    S_TAIL
  } state_e;

  state_e     state_q, state_d;
  mode_e      mode_q, mode_d;
  logic [1:0] pre_n_q, pre_n_d;
  logic [2:0] tail_n_q, tail_n_d;
  logic       has_rep_q, has_rep_d;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;

  logic                acc;
  mode_e               dec_mode;
  sed_pkg::pre_kind_e  pre_kind;
  sed_pkg::tail_kind_e tail_kind;
  logic                plain_esc;
  logic                dec_rep;
  logic                dec_first;
  logic                dec_clear;
  logic                dec_push;
  logic [1:0]          pre_n;
  logic [2:0]          tail_n;
  logic                fin;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_can_load;
  assign acc        = in_ready_o && in_valid_i;
  // a backslash that is not the final byte opens an escape, unless it is itself escaped
  assign plain_esc  = stat_i.is_bs && !in_last_i;

  always_comb begin
    dec_mode  = plain_esc ? MODE_ESCAPE : MODE_NORMAL;
    pre_kind  = sed_pkg::PRE_NONE;
    tail_kind = plain_esc ? sed_pkg::TAIL_NONE : sed_pkg::TAIL_BYTE;
    dec_rep   = 1'b0;
    dec_first = 1'b0;
    dec_clear = 1'b0;
    dec_push  = 1'b0;
    unique case (mode_q)
      MODE_ESCAPE: begin
        dec_mode = MODE_NORMAL;
        if (stat_i.is_esc_char) begin
          tail_kind = sed_pkg::TAIL_CHAR;
        end else if (stat_i.is_bs || stat_i.is_quote) begin
          tail_kind = sed_pkg::TAIL_BYTE;
        end else if ((stat_i.is_x || stat_i.is_u) && !in_last_i) begin
          tail_kind = sed_pkg::TAIL_NONE;
          dec_mode  = stat_i.is_x ? MODE_X_FIRST : MODE_U_OPEN;
        end else begin
          tail_kind = sed_pkg::TAIL_BS_BYTE;
        end
      end
      MODE_X_FIRST: begin
        if (stat_i.hex_ok && !in_last_i) begin
          dec_first = 1'b1;
          dec_mode  = MODE_X_SECOND;
          tail_kind = sed_pkg::TAIL_NONE;
        end else begin
          pre_kind = sed_pkg::PRE_BS_X;
        end
      end
      MODE_X_SECOND: begin
        if (stat_i.hex_ok) begin
          dec_mode  = MODE_NORMAL;
          tail_kind = sed_pkg::TAIL_HEX;
        end else begin
          pre_kind = sed_pkg::PRE_BS_X_H;
        end
      end
      MODE_U_OPEN: begin
        if (stat_i.is_lbrace && !in_last_i) begin
          dec_clear = 1'b1;
          dec_mode  = MODE_U_DIGITS;
          tail_kind = sed_pkg::TAIL_NONE;
        end else begin
          pre_kind = sed_pkg::PRE_BS_U;
        end
      end
      MODE_U_DIGITS: begin
        if (stat_i.is_rbrace && stat_i.cnt_nz && stat_i.cp_ok) begin
          dec_mode  = MODE_NORMAL;
          tail_kind = sed_pkg::TAIL_UTF8;
        end else if (stat_i.hex_ok && !in_last_i && stat_i.grow_ok) begin
          dec_push  = 1'b1;
          dec_mode  = MODE_U_DIGITS;
          tail_kind = sed_pkg::TAIL_NONE;
        end else begin
          // failed code point: replay what was held, then decode this byte afresh
          pre_kind = sed_pkg::PRE_BS_U_BRACE;
          dec_rep  = stat_i.cnt_nz;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (pre_kind)
      sed_pkg::PRE_BS_X, sed_pkg::PRE_BS_U:         pre_n = 2'd2;
      sed_pkg::PRE_BS_X_H, sed_pkg::PRE_BS_U_BRACE: pre_n = 2'd3;
      default:                                      pre_n = 2'd0;
    endcase
    unique case (tail_kind)
      sed_pkg::TAIL_BYTE, sed_pkg::TAIL_CHAR, sed_pkg::TAIL_HEX: tail_n = 3'd1;
      sed_pkg::TAIL_BS_BYTE:                                     tail_n = 3'd2;
      sed_pkg::TAIL_UTF8:                                        tail_n = stat_i.cp_len;
      default:                                                   tail_n = 3'd0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    pre_n_d   = pre_n_q;
    tail_n_d  = tail_n_q;
    has_rep_d = has_rep_q;
    last_d    = last_q;
    idx_d     = idx_q;
    fin       = 1'b0;
    cmd_o     = '0;
    cmd_o.pre_kind  = pre_kind;
    cmd_o.tail_kind = tail_kind;
    cmd_o.sel       = sed_pkg::EMIT_DIRECT;
    cmd_o.idx       = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          mode_d           = dec_mode;
          pre_n_d          = pre_n;
          tail_n_d         = tail_n;
          has_rep_d        = dec_rep;
          last_d           = in_last_i;
          idx_d            = 2'd0;
          cmd_o.load       = 1'b1;
          cmd_o.load_first = dec_first;
          cmd_o.clear_code = dec_clear;
          cmd_o.push_digit = dec_push;
          if (pre_n == 2'd0 && !dec_rep && tail_n == 3'd1) begin
            // a lone result goes straight to the output register
            cmd_o.emit       = 1'b1;
            cmd_o.sel        = sed_pkg::EMIT_DIRECT;
            cmd_o.run_last   = 1'b1;
            cmd_o.string_end = in_last_i;
          end else if (pre_n != 2'd0) begin
            state_d = S_PRE;
          end else if (dec_rep) begin
            state_d = S_REP;
          end else if (tail_n != 3'd0) begin
            state_d = S_TAIL;
          end
        end
      end
      S_PRE: begin
        if (stat_i.out_can_load) begin
          fin            = (idx_q == pre_n_q - 2'd1);
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = sed_pkg::EMIT_PRE;
          cmd_o.run_last = fin && !has_rep_q && (tail_n_q == 3'd0);
          idx_d          = idx_q + 2'd1;
          if (fin) begin
            idx_d = 2'd0;
            if (has_rep_q) begin
              state_d = S_REP;
            end else if (tail_n_q != 3'd0) begin
              state_d = S_TAIL;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_REP: begin
        if (stat_i.out_can_load) begin
          fin            = stat_i.rep_at_end;
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = sed_pkg::EMIT_REP;
          cmd_o.run_last = fin && (tail_n_q == 3'd0);
          if (fin) begin
            idx_d   = 2'd0;
            state_d = (tail_n_q != 3'd0) ? S_TAIL : S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (stat_i.out_can_load) begin
          fin            = ({1'b0, idx_q} == tail_n_q - 3'd1);
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = sed_pkg::EMIT_TAIL;
          cmd_o.run_last = fin;
          idx_d          = idx_q + 2'd1;
          if (fin) begin
            state_d = S_IDLE;
          end
        end
      end
    endcase
    if (state_q != S_IDLE) begin
      cmd_o.string_end = cmd_o.run_last && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_NORMAL;
      pre_n_q   <= '0;
      tail_n_q  <= '0;
      has_rep_q <= 1'b0;
      last_q    <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      pre_n_q   <= pre_n_d;
      tail_n_q  <= tail_n_d;
      has_rep_q <= has_rep_d;
      last_q    <= last_d;
      idx_q     <= idx_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/string_escape_decoder.sv
// a lone result goes to the output register in the cycle after its item is accepted;
// the first of several results passes the sequencer state, then the output register
// an item with no result, or a lone plain or decoded byte, leaves the decoder idle for the next byte;
// an item with n > 1 results, or with a held escape prefix, holds off new input until all are sent,
// since the single output register sends one decoded byte per cycle while the output is not stalled
// reset: rst_ni clears the decode mode, sequencer and output valid at once;
// the held digit bytes are not reset
`default_nettype none
module string_escape_decoder #(
  parameter int MAX_HEX_DIGITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // in_byte
  input  wire logic       s_axis_tlast_i,  // in_last
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // out_byte
  output logic            m_axis_tlast_o,  // run_last
  output logic            m_axis_tuser_o   // string_end
);

  sed_pkg::sed_cmd_t  cmd;
  sed_pkg::sed_stat_t stat;

  sed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sed_dp #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_byte_i        (s_axis_tdata_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_byte_o       (m_axis_tdata_o),
    .out_run_last_o   (m_axis_tlast_o),
    .out_string_end_o (m_axis_tuser_o)
  );

`ifndef NO_ASSERTIONS
  // end of string only on the last byte of an item's results
  a_end_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!m_axis_tuser_o || m_axis_tlast_o))
    else $error("string end flagged on a byte that is not run last");

  // the final byte of a string always yields output before the next item
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=>
      (!s_axis_tready_o || m_axis_tvalid_o))
    else $error("final byte of string produced no result");

  // a new emission never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_can_load)
    else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire
